/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and SHA-256 bit functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned ROUND_COUNT  = 64;
   localparam int unsigned DIGEST_WORDS = 8;

   typedef logic [31:0] word_type;

   // message schedule control
   typedef struct packed {
      logic push;    // shift a loaded message word in at the top
      logic shift;   // advance one round, expanding the next word
   } sched_ctrl_type;

   // round datapath control
   typedef struct packed {
      logic init;     // copy chaining value into the working variables
      logic step;     // run one compression round
      logic fold;     // add working variables into the chaining value
      logic restore;  // return chaining value to the initial hash
   } round_ctrl_type;

   localparam word_type ROUND_K [ROUND_COUNT] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type HASH_IV [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

/* rtl/sha256_sched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_sched
// Sixteen-word message schedule window: loads block words, then expands.
// ----------------------------------------------------------------------------
module sha256_sched
   import sha256_pkg::*;
(
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   input  word_type       load_word,
   output word_type       sched_word
);

   word_type win_ff [BLOCK_WORDS];
   word_type win_in [BLOCK_WORDS];
   word_type expand_word;

   // W[t+16] from taps t, t+1, t+9, t+14
   assign expand_word = small_sigma1(win_ff[14]) + win_ff[9] +
                        small_sigma0(win_ff[1]) + win_ff[0];

   assign sched_word = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctrl.push || ctrl.shift) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[BLOCK_WORDS - 1] = ctrl.push ? load_word : expand_word;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

/* rtl/sha256_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_round
// Shared compression round and chaining value registers.
// ----------------------------------------------------------------------------
module sha256_round
   import sha256_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  logic [5:0]     round_index,
   input  word_type       sched_word,
   input  logic [2:0]     read_index,
   output word_type       hash_word
);

   word_type chain_ff [DIGEST_WORDS];
   word_type chain_in [DIGEST_WORDS];
   word_type vars_ff  [DIGEST_WORDS];
   word_type vars_in  [DIGEST_WORDS];
   word_type temp1;
   word_type temp2;

   assign temp1 = vars_ff[7] + big_sigma1(vars_ff[4]) +
                  choose(vars_ff[4], vars_ff[5], vars_ff[6]) +
                  ROUND_K[round_index] + sched_word;
   assign temp2 = big_sigma0(vars_ff[0]) +
                  majority(vars_ff[0], vars_ff[1], vars_ff[2]);

   assign hash_word = chain_ff[read_index];

   always_comb begin
      vars_in = vars_ff;
      if (ctrl.init) begin
         vars_in = chain_ff;
      end else if (ctrl.step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + temp1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = temp1 + temp2;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.restore) begin
         chain_in = HASH_IV;
      end else if (ctrl.fold) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= HASH_IV;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

/* rtl/sha256_message_hash_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hash_core
// Byte-serial SHA-256 hash: collects message bytes, pads, emits the digest.
// ----------------------------------------------------------------------------
//
//  channel  direction  word carries
//  -------  ---------  ---------------------------------------------------
//  req_*    in         tdata = message byte, tuser = byte present,
//                      tlast = end of message
//  rsp_*    out        tdata = digest word [31:0], word position [34:32],
//                      zero [39:35]; tlast = eighth digest word
//
//  A byte that does not complete a 64-byte block leaves the input open. A
//  byte that completes one is accepted, then runs 64 rounds of the shared
//  round unit and one fold into the chaining value.
//  End of message pads (up to 72 padding bytes), compresses and folds each
//  padded block (one or two), then hands out eight digest words.
//  req_tready is low while a block compresses, while padding runs and while
//  the digest is out; a stalled rsp_tready holds the current digest word.
//  Synchronous active-high reset loads the initial hash and clears counts.
// ----------------------------------------------------------------------------
module sha256_message_hash_core
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] message_byte
   input  logic        req_tuser,    // [0] byte_present
   input  logic        req_tlast,    // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [31:0] digest_word, [34:32] word_position
   output logic        rsp_tlast     // last_word
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FOLD  = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LEN_OFFSET  = 6'd56;
   localparam logic [5:0] LAST_BYTE   = 6'd63;
   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [2:0] LAST_WORD   = 3'd7;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [23:0] word_ff, word_in;
   logic        pad_pend_ff, pad_pend_in;    // padding still owed
   logic        pad_first_ff, pad_first_in;  // marker byte not yet placed
   logic        len_ok_ff, len_ok_in;        // this block carries the length

   logic           req_fire;
   logic           rsp_fire;
   logic           push_en;
   logic [7:0]     push_byte;
   logic [7:0]     pad_byte;
   logic           block_full;
   sched_ctrl_type sched_ctrl;
   round_ctrl_type round_ctrl;
   word_type       sched_word;
   word_type       hash_word;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'd0, idx_ff, hash_word};
   assign rsp_tlast  = (idx_ff == LAST_WORD);

   // padding byte: marker, then zeros, then the big-endian bit length
   always_comb begin
      priority if (pad_first_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_ok_ff && (fill_ff >= LEN_OFFSET)) begin
         pad_byte = bit_count_ff[{~fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'd0;
      end
   end

   // one byte path shared by message bytes and padding
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            push_en   = req_fire && req_tuser;
            push_byte = req_tdata;
         end
         S_PAD: begin
            push_en   = 1'b1;
            push_byte = pad_byte;
         end
         default: begin
            push_en   = 1'b0;
            push_byte = req_tdata;
         end
      endcase
   end

   assign block_full = push_en && (fill_ff == LAST_BYTE);

   assign sched_ctrl.push  = push_en && (fill_ff[1:0] == 2'b11);
   assign sched_ctrl.shift = (state_ff == S_ROUND);

   assign round_ctrl.init    = block_full;
   assign round_ctrl.step    = (state_ff == S_ROUND);
   assign round_ctrl.fold    = (state_ff == S_FOLD);
   assign round_ctrl.restore = rsp_fire && rsp_tlast;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      bit_count_in = bit_count_ff;
      word_in      = word_ff;
      pad_pend_in  = pad_pend_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;

      if (push_en) begin
         word_in = {word_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  bit_count_in = bit_count_ff + BYTE_BITS;
               end
               if (req_tlast) begin
                  pad_pend_in  = 1'b1;
                  pad_first_in = 1'b1;
                  len_ok_in    = 1'b0;
               end
               priority if (block_full) begin
                  state_in = S_ROUND;
                  rnd_in   = 6'd0;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            if (pad_first_ff) begin
               pad_first_in = 1'b0;
               len_ok_in    = (fill_ff < LEN_OFFSET);
            end
            if (block_full) begin
               state_in = S_ROUND;
               rnd_in   = 6'd0;
            end
         end
         S_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            priority if (!pad_pend_ff) begin
               state_in = S_IDLE;
            end else if (len_ok_ff) begin
               // length block done: hand out the digest
               state_in    = S_OUT;
               idx_in      = 3'd0;
               pad_pend_in = 1'b0;
            end else begin
               // marker not yet placed or landed past the length field: one more block
               if (!pad_first_ff) begin
                  len_ok_in = 1'b1;
               end
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (rsp_tlast) begin
                  state_in     = S_IDLE;
                  bit_count_in = 64'd0;
                  fill_in      = 6'd0;
                  len_ok_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= 6'd0;
         rnd_ff       <= 6'd0;
         idx_ff       <= 3'd0;
         bit_count_ff <= 64'd0;
         pad_pend_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         bit_count_ff <= bit_count_in;
         pad_pend_ff  <= pad_pend_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   sha256_sched u_sched (
      .clock      (clock),
      .ctrl       (sched_ctrl),
      .load_word  ({word_ff, push_byte}),
      .sched_word (sched_word)
   );

   sha256_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (round_ctrl),
      .round_index (rnd_ff),
      .sched_word  (sched_word),
      .read_index  (idx_ff),
      .hash_word   (hash_word)
   );

   // a block always starts compressing on its first round
   assert property (@(posedge clock) disable iff (reset)
      (block_full |=> (state_ff == S_ROUND) && (rnd_ff == 6'd0)))
      else $error("block not handed to round unit");

   // length is placed only after the marker byte
   assert property (@(posedge clock) disable iff (reset)
      (len_ok_ff |-> !pad_first_ff))
      else $error("length enabled before padding marker");

   // digest closes the message: counts cleared, input open again
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast |=> (bit_count_ff == 64'd0) && (fill_ff == 6'd0)
                                  && req_tready))
      else $error("state not cleared after digest");

   // digest only follows a finished length block, with the fill count back at zero
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FOLD) && pad_pend_ff && len_ok_ff |-> (fill_ff == 6'd0)))
      else $error("digest out with partial block");

endmodule

/* tb/hash_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_scoreboard_pkg
// Digest predictor and scoreboard for the byte-serial SHA-256 core.
// ----------------------------------------------------------------------------
package hash_scoreboard_pkg;

   localparam bit [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam bit [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int unsigned LENGTH_SLOT = 56;

   typedef struct {
      bit [31:0] digest_word;
      bit [2:0]  word_position;
      bit        last_word;
   } digest_entry_type;

   class digest_scoreboard;
      bit [31:0]        chain [8];
      bit [7:0]         blk [64];
      bit [63:0]        bit_total;
      int unsigned      fill;
      digest_entry_type digest_queue [$];
      int unsigned      mismatches;
      int unsigned      words_checked;
      int unsigned      messages;

      function new();
         restart();
         mismatches    = 0;
         words_checked = 0;
         messages      = 0;
      endfunction

      function void restart();
         chain     = START_HASH;
         bit_total = '0;
         fill      = 0;
      endfunction

      function bit [31:0] ror32(bit [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // one 64-round compression of blk into the chaining value
      function void compress();
         bit [31:0] w [16];
         bit [31:0] v [8];
         bit [31:0] wr, t1, t2, m2, m15, s0, s1;
         int        r, j;
         for (j = 0; j < 16; j++)
            w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
         v = chain;
         for (r = 0; r < 64; r++) begin
            if (r < 16) begin
               wr = w[r];
            end else begin
               m2  = w[(r - 2) & 15];
               m15 = w[(r - 15) & 15];
               s1  = ror32(m2, 17) ^ ror32(m2, 19) ^ (m2 >> 10);
               s0  = ror32(m15, 7) ^ ror32(m15, 18) ^ (m15 >> 3);
               wr  = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
               w[r & 15] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (j = 0; j < 8; j++)
            chain[j] += v[j];
      endfunction

      // take one accepted input word; queue the digest when it closes a message
      function void note_word(bit [7:0] data, bit present, bit closing);
         digest_entry_type e;
         int               j;
         if (present) begin
            blk[fill] = data;
            bit_total += 64'd8;
            fill++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end
         if (!closing)
            return;
         blk[fill] = 8'h80;
         for (j = fill + 1; j < 64; j++)
            blk[j] = 8'h00;
         if (fill >= LENGTH_SLOT) begin
            compress();
            for (j = 0; j < 64; j++)
               blk[j] = 8'h00;
         end
         for (j = 0; j < 8; j++)
            blk[63 - j] = bit_total[8*j +: 8];
         compress();
         for (j = 0; j < 8; j++) begin
            e.digest_word   = chain[j];
            e.word_position = 3'(j);
            e.last_word     = (j == 7);
            digest_queue    = {digest_queue, e};
         end
         messages++;
         restart();
      endfunction

      // compare one accepted digest word with the oldest one predicted
      function void check_word(bit [31:0] digest, bit [2:0] position, bit last);
         digest_entry_type e;
         words_checked++;
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h at position %0d", digest, position);
            mismatches++;
            return;
         end
         e = digest_queue.pop_front();
         if (digest !== e.digest_word) begin
            $error("digest_word: expected %h, got %h", e.digest_word, digest);
            mismatches++;
         end
         if (position !== e.word_position) begin
            $error("word_position: expected %0d, got %0d", e.word_position, position);
            mismatches++;
         end
         if (last !== e.last_word) begin
            $error("last_word: expected %0b, got %0b", e.last_word, last);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return digest_queue.size();
      endfunction
   endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams random and corner-case messages into the SHA-256 core with bursty
// input and a stalling digest port, and checks every digest word.
// ----------------------------------------------------------------------------
module testbench;
   import hash_scoreboard_pkg::*;

   localparam int unsigned STALL_LIMIT   = 5000;  // cycles with no word moving
   localparam int unsigned TAIL_CYCLES   = 400;   // settle time after the last digest
   localparam int unsigned RANDOM_TARGET = 250;   // random words that carry data or close

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] message_byte
   logic        req_tuser;    // [0] byte_present
   logic        req_tlast;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [31:0] digest_word, [34:32] word_position
   logic        rsp_tlast;    // last_word

   digest_scoreboard sb;

   int unsigned burst_left;
   int unsigned random_words;
   int unsigned words_in;
   int unsigned idle_cycles;
   int unsigned ready_mode;
   int unsigned ready_hold;
   int unsigned cycle_count;

   sha256_message_hash_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge. Check digest words before noting
   // input, although the core never takes a byte while a digest is going out.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
         if (req_tvalid && req_tready) begin
            sb.note_word(req_tdata, req_tuser, req_tlast);
            words_in++;
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Digest-side back-pressure: switch between always ready, coin flips,
   // a fixed one-in-four stall and a mode that is ready one time in eight.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else begin
         cycle_count++;
         if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(80, 400);
         end else begin
            ready_hold--;
         end
         case (ready_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = (cycle_count % 4) != 3;
            default: rsp_tready = ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Drive one input word and hold it until the core takes it. Between bursts
   // drop tvalid for a random gap, with garbage on the data lines.
   task automatic send_word(input logic [7:0] data, input logic present,
                            input logic closing);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom_range(0, 255));
            req_tuser  = 1'($urandom_range(0, 1));
            req_tlast  = 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = present;
      req_tlast  = closing;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Send a message of the given length, now and then with idle words mixed
   // in. Close it on the last byte or with a separate empty closing word.
   task automatic send_message(input int unsigned len, input bit close_on_byte);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
         random_words++;
      end
      if (!close_on_byte || len == 0) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         random_words++;
      end
   endtask

   initial begin
      int unsigned pick;
      int unsigned len;
      bit          on_byte;

      sb           = new();
      burst_left   = 0;
      random_words = 0;
      words_in     = 0;
      idle_cycles  = 0;
      ready_mode   = 0;
      ready_hold   = 0;
      cycle_count  = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tuser    = 1'b0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: an idle word, the empty message twice in a row, one-byte
      // messages at both byte extremes, "abc", and a short message with an
      // idle word inside that closes on an empty word.
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'h12, 1'b1, 1'b0);
      send_word(8'hc5, 1'b0, 1'b0);
      send_word(8'h34, 1'b1, 1'b0);
      send_word(8'h5a, 1'b0, 1'b1);

      // Random: mostly short messages, some sized around the padding and
      // block boundaries so the extra padding block and full-block paths run.
      while (random_words < RANDOM_TARGET) begin
         pick    = $urandom_range(0, 9);
         on_byte = $urandom_range(0, 1);
         if (pick < 7) begin
            len = $urandom_range(0, 12);
         end else begin
            case ($urandom_range(0, 7))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               default: len = 120;
            endcase
         end
         // trim the last message so the run stays near its word budget
         if (len > RANDOM_TARGET - random_words) begin
            len = RANDOM_TARGET - random_words;
         end
         send_message(len, on_byte);
      end

      // Release the input, drain every predicted digest, then settle.
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.pending() != 0) begin
         $error("%0d digest words never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("Hashed %0d messages from %0d input words; %0d digest words checked.",
               sb.messages, words_in, sb.words_checked);
      $display("Covered empty, one-byte and block-boundary messages under stalls.");
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_round.sv
rtl/sha256_message_hash_core.sv
tb/hash_scoreboard_pkg.sv
tb/testbench.sv
